// ----- hw/rtl/spr_pkg.sv -----
// Shared types and constants of the servo packet receiver.
package spr_pkg;

    localparam int unsigned FRAME_BUF_DEPTH = 8;
    localparam int unsigned COUNT_W         = $clog2(FRAME_BUF_DEPTH + 1);
    localparam int unsigned MAX_FRAME_LEN   = 7;
    localparam int unsigned IDX_W           = 3;
    localparam int unsigned LEN_W           = 3;
    localparam int unsigned GRP_W           = 7;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned CODE_W          = 5;
    localparam int unsigned VALUE_W         = 29;
    localparam int unsigned Q_DEPTH         = 2;
    localparam int unsigned Q_PTR_W         = 1;
    localparam int unsigned Q_CNT_W         = 2;

    localparam logic [LEN_W-1:0]  LEN_BASE     = 3'd4;
    localparam logic [CODE_W-1:0] CODE_ABS_POS = 5'h1b;
    localparam logic [CODE_W-1:0] UNSIGNED_LO  = 5'h10;
    localparam logic [CODE_W-1:0] UNSIGNED_HI  = 5'h17;

    typedef logic [GRP_W-1:0] t_group;

    typedef struct packed {
        logic [LEN_W-1:0]                len;
        t_group [MAX_FRAME_LEN-1:0]      grp;
    } t_frame;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_back_state;

endpackage

// ----- hw/rtl/servo_packet_receiver.sv -----
// Top level of the servo packet receiver: front end, frame queue and decoder.
//
// Usage: received serial bytes enter through a queue-like port. A byte is taken
// in the transaction where push is high and full is low. A byte with bit 7 clear
// opens a frame; bytes with bit 7 set extend it, and the second byte fixes the
// frame length at four to seven bytes. When the last byte of a frame arrives,
// one result becomes available on the output side, which also looks like a
// queue: the result sits on the ports while empty is low and leaves in the
// transaction where pop is high and empty is low.
// The result of a frame passes through the queue, the decoder's idle, walk and
// done states and the output register after its last byte is taken. Bytes are
// taken one per cycle while full is low; the decoder walks one stored byte per
// cycle and takes a new frame from the queue only after it has loaded the result
// of the last one into the output register.
// A two-entry frame queue sits between the front end and the decoder, so bytes
// keep flowing while a frame is being decoded. When the consumer stalls, the
// decoder holds its result, the queue fills, and full rises; the byte that
// would complete a frame is only taken while the queue has room.
// Reset (synchronous, active low) drops any partial frame, empties the queue
// and the output register; no clearing pass is needed.
module servo_packet_receiver (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        i_rx_byte,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_status,
    output logic [6:0]                        o_axis_id,
    output logic [4:0]                        o_func_code,
    output logic signed [spr_pkg::VALUE_W-1:0] o_data_value,
    output logic                              o_position_report
);

    // Frame handoff between the front end and the queue.
    logic            fq_push;
    logic            fq_full;
    spr_pkg::t_frame fq_frame;

    // Frame handoff between the queue and the decoder.
    logic            bq_pop;
    logic            bq_empty;
    spr_pkg::t_frame bq_frame;

    // The front end tracks the byte count and frame length and keeps the
    // low seven bits of each stored byte; only those bits matter downstream.
    spr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_rx_byte (i_rx_byte),
        .i_q_full  (fq_full),
        .o_q_push  (fq_push),
        .o_q_frame (fq_frame)
    );

    // A finished frame is copied whole into the queue, so a new frame can
    // start filling the front end while the decoder is still busy.
    spr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_frame (fq_frame),
        .o_full  (fq_full),
        .i_pop   (bq_pop),
        .o_empty (bq_empty),
        .o_frame (bq_frame)
    );

    // The decoder sums the checksum and assembles the value over the stored
    // groups, then loads the single-entry output register.
    spr_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (bq_empty),
        .i_q_frame         (bq_frame),
        .o_q_pop           (bq_pop),
        .empty             (empty),
        .pop               (pop),
        .o_status          (o_status),
        .o_axis_id         (o_axis_id),
        .o_func_code       (o_func_code),
        .o_data_value      (o_data_value),
        .o_position_report (o_position_report)
    );

endmodule

// ----- hw/rtl/spr_front.sv -----
// Front end: collects received bytes into frames and hands finished frames on.
module spr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output spr_pkg::t_frame      o_q_frame
);

    logic [spr_pkg::COUNT_W-1:0] r_count, n_count;
    logic [spr_pkg::LEN_W-1:0]   r_len, n_len;
    spr_pkg::t_group [spr_pkg::MAX_FRAME_LEN-1:0] r_grp, n_grp;

    logic                        accept;
    logic                        start;
    logic                        store;
    logic                        complete;
    logic [spr_pkg::COUNT_W-1:0] base_count;
    logic [spr_pkg::LEN_W-1:0]   base_len;

    assign full   = i_q_full;
    assign accept = push & ~i_q_full;
    assign start  = ~i_rx_byte[7];

    always_comb begin
        base_count = start ? '0 : r_count;
        base_len   = start ? '0 : r_len;
        store      = start || (r_count != '0 &&
                     r_count < spr_pkg::COUNT_W'(spr_pkg::FRAME_BUF_DEPTH));
        n_count    = base_count + spr_pkg::COUNT_W'(1);
        n_len      = base_len;
        // The second byte of a frame fixes its length.
        if (n_count == spr_pkg::COUNT_W'(2)) begin
            n_len = spr_pkg::LEN_BASE + {1'b0, i_rx_byte[6:5]};
        end
        n_grp = r_grp;
        if (base_count < spr_pkg::COUNT_W'(spr_pkg::MAX_FRAME_LEN)) begin
            n_grp[base_count[spr_pkg::IDX_W-1:0]] = i_rx_byte[6:0];
        end
        complete = store && n_len != '0 &&
                   n_count == spr_pkg::COUNT_W'(n_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_len   <= '0;
        end else if (accept && store) begin
            r_count <= n_count;
            r_len   <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && store) begin
            r_grp <= n_grp;
        end
    end

    assign o_q_push      = accept & complete;
    assign o_q_frame.len = n_len;
    assign o_q_frame.grp = n_grp;

endmodule

// ----- hw/rtl/spr_queue.sv -----
// Two-entry frame queue between the front end and the decoder.
module spr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  spr_pkg::t_frame i_frame,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output spr_pkg::t_frame o_frame
);

    spr_pkg::t_frame r_mem [spr_pkg::Q_DEPTH];
    logic [spr_pkg::Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [spr_pkg::Q_CNT_W-1:0] r_cnt;
    logic do_push, do_pop;

    assign o_full  = r_cnt == spr_pkg::Q_CNT_W'(spr_pkg::Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_frame = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + spr_pkg::Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + spr_pkg::Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + spr_pkg::Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - spr_pkg::Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

// ----- hw/rtl/spr_back.sv -----
// Decoder: walks a frame one group per cycle and holds the result for the consumer.
module spr_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_empty,
    input  spr_pkg::t_frame                   i_q_frame,
    output logic                              o_q_pop,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_status,
    output logic [6:0]                        o_axis_id,
    output logic [4:0]                        o_func_code,
    output logic signed [spr_pkg::VALUE_W-1:0] o_data_value,
    output logic                              o_position_report
);

    spr_pkg::t_back_state r_state, n_state;
    spr_pkg::t_frame      r_frame;
    logic [spr_pkg::IDX_W-1:0]   r_idx;
    logic [spr_pkg::GRP_W-1:0]   r_sum;
    logic [spr_pkg::VALUE_W-1:0] r_val;
    logic                        r_err;
    logic                        r_out_valid;

    logic                         out_free;
    logic                         load_out;
    logic                         step;
    logic                         last;
    logic                         is_unsigned;
    spr_pkg::t_group              grp;
    logic [spr_pkg::CODE_W-1:0]   code;
    logic [spr_pkg::VALUE_W-1:0]  first_val;

    assign out_free    = ~r_out_valid | pop;
    assign grp         = r_frame.grp[r_idx];
    assign code        = r_frame.grp[1][spr_pkg::CODE_W-1:0];
    assign last        = r_idx == (r_frame.len - spr_pkg::LEN_W'(1));
    assign is_unsigned = code >= spr_pkg::UNSIGNED_LO && code <= spr_pkg::UNSIGNED_HI;
    assign first_val   = {{(spr_pkg::VALUE_W - spr_pkg::GRP_W){grp[6] & ~is_unsigned}}, grp};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spr_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = spr_pkg::ST_WALK;
                end
            end
            spr_pkg::ST_WALK: begin
                if (last) begin
                    n_state = spr_pkg::ST_DONE;
                end
            end
            spr_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = spr_pkg::ST_IDLE;
                end
            end
            default: n_state = spr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop  = 1'b0;
        step     = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            spr_pkg::ST_IDLE: o_q_pop  = ~i_q_empty;
            spr_pkg::ST_WALK: step     = 1'b1;
            spr_pkg::ST_DONE: load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spr_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_frame <= i_q_frame;
            r_idx   <= '0;
            r_sum   <= '0;
        end
        if (step) begin
            r_idx <= r_idx + spr_pkg::IDX_W'(1);
            if (last) begin
                r_err <= (r_sum ^ grp) != '0;
            end else begin
                r_sum <= r_sum + grp;
                if (r_idx == spr_pkg::IDX_W'(2)) begin
                    r_val <= first_val;
                end else if (r_idx > spr_pkg::IDX_W'(2)) begin
                    r_val <= {r_val[spr_pkg::VALUE_W-spr_pkg::GRP_W-1:0], grp};
                end
            end
        end
        if (load_out) begin
            o_status          <= r_err;
            o_axis_id         <= r_err ? '0 : r_frame.grp[0];
            o_func_code       <= r_err ? '0 : code;
            o_data_value      <= r_err ? '0 : r_val;
            o_position_report <= ~r_err && code == spr_pkg::CODE_ABS_POS;
        end
    end

    assign empty = ~r_out_valid;

endmodule
